// ----- sv/bmsrp_pkg.sv -----
// Shared types and constants for the battery-monitor reply frame parser.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package bmsrp_pkg;

    // Storage and field sizing.
    localparam int INFO_DEPTH  = 64;
    localparam int INFO_AW     = $clog2(INFO_DEPTH);
    localparam int MAX_SENSORS = 8;
    localparam int SENS_W      = $clog2(MAX_SENSORS + 1);
    localparam int FID_W       = 5;

    // Frame layout.
    localparam logic [7:0] START_BYTE  = 8'hDD;
    localparam logic [7:0] END_BYTE    = 8'h77;
    localparam int         WORD_FIELDS = 9;
    localparam int         BYTE_FIELDS = 4;
    localparam int         FIXED_INFO  = 23;
    localparam int         COUNT_FID   = WORD_FIELDS + BYTE_FIELDS;
    localparam int         LAST_FID    = COUNT_FID + MAX_SENSORS;

    // Configuration register map.
    localparam int         ADDR_W          = 3;
    localparam logic [0:0] REG_EXPECTED_CMD = 1'b0;
    localparam logic [7:0] EXPECTED_CMD_RST = 8'h03;

    // Position within the reply frame.
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_CMD,
        PH_STATUS,
        PH_LEN,
        PH_INFO,
        PH_CHK_HI,
        PH_CHK_LO,
        PH_END
    } t_phase;

    // Result status codes.
    typedef enum logic [2:0] {
        FS_OK      = 3'd0,
        FS_BAD_CMD = 3'd1,
        FS_BAD_END = 3'd2,
        FS_BAD_SUM = 3'd3,
        FS_BAD_LEN = 3'd4
    } t_frame_status;

    // Controller states.
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_NREAD,
        CS_CHECK,
        CS_RD_HI,
        CS_RD_LO,
        CS_LOAD
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd_n;
        logic start_run;
        logic load_err;
        logic rd_byte;
        logic cap_hi;
        logic load_field;
        logic next_field;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic end_pos;
        logic frame_bad;
        logic out_busy;
        logic word_field;
        logic last_field;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- sv/bmsrp_ctrl.sv -----
// Controller state machine of the reply frame parser: byte acceptance and
// sequencing of the result run. Depends on bmsrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmsrp_ctrl
    import bmsrp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            CS_IDLE: begin
                if (i_valid && i_sts.end_pos) begin
                    n_state = CS_NREAD;
                end
            end
            CS_NREAD: begin
                n_state = CS_CHECK;
            end
            CS_CHECK: begin
                if (!i_sts.frame_bad) begin
                    n_state = CS_RD_HI;
                end else if (!i_sts.out_busy) begin
                    n_state = CS_IDLE;
                end
            end
            CS_RD_HI: begin
                n_state = i_sts.word_field ? CS_RD_LO : CS_LOAD;
            end
            CS_RD_LO: begin
                n_state = CS_LOAD;
            end
            CS_LOAD: begin
                if (!i_sts.out_busy) begin
                    n_state = i_sts.last_field ? CS_IDLE : CS_RD_HI;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            CS_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            CS_NREAD: begin
                o_cmd.rd_n = 1'b1;
            end
            CS_CHECK: begin
                o_cmd.start_run = !i_sts.frame_bad;
                o_cmd.load_err  = i_sts.frame_bad && !i_sts.out_busy;
            end
            CS_RD_HI: begin
                o_cmd.rd_byte = 1'b1;
            end
            CS_RD_LO: begin
                o_cmd.rd_byte = 1'b1;
                o_cmd.cap_hi  = 1'b1;
            end
            CS_LOAD: begin
                o_cmd.load_field = !i_sts.out_busy;
                o_cmd.next_field = !i_sts.out_busy && !i_sts.last_field;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/bmsrp_datapath.sv -----
// Datapath of the reply frame parser: framing registers, checksum, info byte
// memory, configuration register and output register. Depends on bmsrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmsrp_datapath
    import bmsrp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_after_idle,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output logic [FID_W-1:0]       o_field_id,
    output logic [15:0]            o_value,
    output logic [2:0]             o_status,
    output logic                   o_last,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata
);

    // Framing state.
    t_phase      r_phase, n_phase, phase_eff;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_sum, n_sum;
    logic        r_cmd_ok, n_cmd_ok;
    logic [7:0]  r_chk_hi, n_chk_hi;
    logic [7:0]  r_chk_lo, n_chk_lo;
    logic        r_end_ok, n_end_ok;
    logic [7:0]  r_exp_cmd;

    // Run state and memory.
    logic [7:0]         r_info_mem [INFO_DEPTH];
    logic [7:0]         r_rdata;
    logic [7:0]         r_hi;
    logic [SENS_W-1:0]  r_n;
    logic [INFO_AW-1:0] r_ptr;
    logic [FID_W-1:0]   r_fid;
    logic               mem_wr;
    logic               mem_rd;
    logic [INFO_AW-1:0] rd_addr;

    // Output register.
    logic               r_out_valid;
    logic [FID_W-1:0]   r_out_fid;
    logic [15:0]        r_out_value;
    t_frame_status      r_out_status;
    logic               r_out_last;

    t_frame_status      frame_err;
    logic [15:0]        exp_sum;
    logic [9:0]         min_len;

    // An idle break abandons the partial frame before the byte is parsed.
    assign phase_eff = i_after_idle ? PH_HUNT : r_phase;

    // Frame parsing on each accepted byte.
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_len    = r_len;
        n_sum    = r_sum;
        n_cmd_ok = r_cmd_ok;
        n_chk_hi = r_chk_hi;
        n_chk_lo = r_chk_lo;
        n_end_ok = r_end_ok;
        if (i_cmd.accept) begin
            n_phase = phase_eff;
            case (phase_eff)
                PH_HUNT: begin
                    if (i_rx_byte == START_BYTE) begin
                        n_phase  = PH_CMD;
                        n_count  = '0;
                        n_len    = '0;
                        n_sum    = '0;
                        n_cmd_ok = 1'b0;
                    end
                end
                PH_CMD: begin
                    n_cmd_ok = (i_rx_byte == r_exp_cmd);
                    n_phase  = PH_STATUS;
                end
                PH_STATUS: begin
                    n_sum   = r_sum + {8'd0, i_rx_byte};
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_sum   = r_sum + {8'd0, i_rx_byte};
                    n_len   = i_rx_byte;
                    n_count = '0;
                    n_phase = (i_rx_byte == 8'd0) ? PH_CHK_HI : PH_INFO;
                end
                PH_INFO: begin
                    n_sum   = r_sum + {8'd0, i_rx_byte};
                    n_count = r_count + 8'd1;
                    if (({1'b0, r_count} + 9'd1) >= {1'b0, r_len}) begin
                        n_phase = PH_CHK_HI;
                    end
                end
                PH_CHK_HI: begin
                    n_chk_hi = i_rx_byte;
                    n_phase  = PH_CHK_LO;
                end
                PH_CHK_LO: begin
                    n_chk_lo = i_rx_byte;
                    n_phase  = PH_END;
                end
                default: begin
                    n_end_ok = (i_rx_byte == END_BYTE);
                    n_phase  = PH_HUNT;
                end
            endcase
        end
    end

    // Framing and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_count   <= '0;
            r_len     <= '0;
            r_sum     <= '0;
            r_cmd_ok  <= 1'b0;
            r_chk_hi  <= '0;
            r_chk_lo  <= '0;
            r_end_ok  <= 1'b0;
            r_exp_cmd <= EXPECTED_CMD_RST;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_len    <= n_len;
            r_sum    <= n_sum;
            r_cmd_ok <= n_cmd_ok;
            r_chk_hi <= n_chk_hi;
            r_chk_lo <= n_chk_lo;
            r_end_ok <= n_end_ok;
            if (psel && penable && pwrite && paddr[2] == REG_EXPECTED_CMD) begin
                r_exp_cmd <= pwdata[7:0];
            end
        end
    end

    // Register read-back.
    assign prdata = (paddr[2] == REG_EXPECTED_CMD) ? {24'd0, r_exp_cmd} : 32'd0;

    // Info byte memory: bytes past the storage depth are summed but dropped.
    assign mem_wr  = i_cmd.accept && (phase_eff == PH_INFO)
                     && ({1'b0, r_count} < 9'(INFO_DEPTH));
    assign mem_rd  = i_cmd.rd_n || i_cmd.rd_byte;
    assign rd_addr = i_cmd.rd_n ? INFO_AW'(FIXED_INFO - 1) : r_ptr;

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_info_mem[r_count[INFO_AW-1:0]] <= i_rx_byte;
        end
        if (mem_rd) begin
            r_rdata <= r_info_mem[rd_addr];
        end
    end

    // Frame check: the read data holds the sensor count while checking.
    assign exp_sum = ~r_sum + 16'd1;
    assign min_len = 10'(FIXED_INFO) + {1'b0, r_rdata, 1'b0};

    always_comb begin
        if (!r_cmd_ok) begin
            frame_err = FS_BAD_CMD;
        end else if (!r_end_ok) begin
            frame_err = FS_BAD_END;
        end else if (exp_sum != {r_chk_hi, r_chk_lo}) begin
            frame_err = FS_BAD_SUM;
        end else if (({1'b0, r_len} > 9'(INFO_DEPTH)) || (r_len < 8'(FIXED_INFO))
                     || (r_rdata > 8'(MAX_SENSORS)) || ({2'd0, r_len} < min_len)) begin
            frame_err = FS_BAD_LEN;
        end else begin
            frame_err = FS_OK;
        end
    end

    // Result run: read pointer, field index and captured high byte.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_run) begin
            r_n   <= r_rdata[SENS_W-1:0];
            r_ptr <= '0;
            r_fid <= '0;
        end else begin
            if (i_cmd.rd_byte) begin
                r_ptr <= r_ptr + INFO_AW'(1);
            end
            if (i_cmd.next_field) begin
                r_fid <= r_fid + FID_W'(1);
            end
        end
        if (i_cmd.cap_hi) begin
            r_hi <= r_rdata;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_err || i_cmd.load_field) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_out_fid    <= '0;
            r_out_value  <= '0;
            r_out_status <= frame_err;
            r_out_last   <= 1'b1;
        end else if (i_cmd.load_field) begin
            r_out_fid    <= r_fid;
            r_out_value  <= o_sts.word_field ? {r_hi, r_rdata} : {8'd0, r_rdata};
            r_out_status <= FS_OK;
            r_out_last   <= o_sts.last_field;
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts.end_pos    = (phase_eff == PH_END);
        o_sts.frame_bad  = (frame_err != FS_OK);
        o_sts.out_busy   = r_out_valid && !i_ready;
        o_sts.word_field = (r_fid < FID_W'(WORD_FIELDS)) || (r_fid > FID_W'(COUNT_FID));
        o_sts.last_field = (r_fid == (FID_W'(COUNT_FID) + FID_W'(r_n)));
    end

    assign o_valid    = r_out_valid;
    assign o_field_id = r_out_fid;
    assign o_value    = r_out_value;
    assign o_status   = r_out_status;
    assign o_last     = r_out_last;

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_field || i_cmd.load_err) |-> !(r_out_valid && !i_ready))
        else $error("result loaded while output register busy");

    // An error result always closes its run.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != FS_OK) |-> (o_last && o_field_id == '0))
        else $error("error result is not a single final result");

    // Good results never run past the last sensor field.
    a_fid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == FS_OK) |-> (o_field_id <= FID_W'(LAST_FID)))
        else $error("field id beyond last sensor");

endmodule

`default_nettype wire

// ----- sv/bms_reply_frame_parser_top.sv -----
// Battery-monitor reply frame parser. After the end byte, the run reads the
// sensor count and checks the frame, then for each word field reads the high
// and low byte, for each byte field one byte, and loads the field as a result;
// a bad frame gives a single error result. The run waits on a stalled output.
// No byte is accepted during a run. Reset is synchronous, active low, and
// returns the parser to hunting for a start byte with command code 3.
`timescale 1ns / 1ps
`default_nettype none

module bms_reply_frame_parser_top
    import bmsrp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_after_idle,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [FID_W-1:0]       o_field_id,
    output logic [15:0]            o_value,
    output logic [2:0]             o_status,
    output logic                   o_last,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // The register port never inserts wait states.
    assign pready = 1'b1;

    // Controller.
    bmsrp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath.
    bmsrp_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_rx_byte    (i_rx_byte),
        .i_after_idle (i_after_idle),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_field_id   (o_field_id),
        .o_value      (o_value),
        .o_status     (o_status),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata)
    );

endmodule

`default_nettype wire
